/* hdl/sdes_pkg.sv */
// shared types, permutation functions and s-box tables for the s-des byte cipher
// no dependencies; used by the key schedule, the round logic and the top level
package sdes_pkg;

	localparam int unsigned KeyW  = 10;
	localparam int unsigned ByteW = 8;
	localparam int unsigned NibW  = 4;

	typedef logic [KeyW-1:0]  key_t;
	typedef logic [ByteW-1:0] byte_t;
	typedef logic [NibW-1:0]  nib_t;

	typedef struct packed {
		byte_t k1;
		byte_t k2;
	} subkeys_t;

	// s-box tables indexed by {row, col}
	localparam logic [1:0] SBOX0 [0:15] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2
	};
	localparam logic [1:0] SBOX1 [0:15] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3
	};

	function automatic key_t perm_p10(input key_t k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic byte_t perm_p8(input key_t k);
		return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
	endfunction

	function automatic byte_t perm_ip(input byte_t b);
		return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
	endfunction

	function automatic byte_t perm_ipinv(input byte_t b);
		return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
	endfunction

	function automatic byte_t perm_ep(input nib_t r);
		return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
	endfunction

	function automatic nib_t perm_p4(input nib_t s);
		return {s[2], s[0], s[1], s[3]};
	endfunction

	// left rotate of each five-bit half
	function automatic key_t rot1_halves(input key_t v);
		return {v[8:5], v[9], v[3:0], v[4]};
	endfunction

	function automatic key_t rot2_halves(input key_t v);
		return {v[7:5], v[9:8], v[2:0], v[4:3]};
	endfunction

	// row from outer bits, column from inner bits
	function automatic logic [3:0] sbox_idx(input nib_t n);
		return {n[3], n[0], n[2:1]};
	endfunction

endpackage

/* hdl/sdes_keysched.sv */
// key schedule: derives and holds both round subkeys when the key is written
// depends on sdes_pkg
module sdes_keysched (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_we,
	input  sdes_pkg::key_t     key_wdata,
	output sdes_pkg::subkeys_t subkeys
);

	sdes_pkg::key_t     rot1;
	sdes_pkg::key_t     rot2;
	sdes_pkg::subkeys_t subkeys_q;

	assign rot1 = sdes_pkg::rot1_halves(sdes_pkg::perm_p10(key_wdata));
	assign rot2 = sdes_pkg::rot2_halves(rot1);

	// a zero key gives zero subkeys, so reset clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkeys_q <= '0;
		end else if (key_we) begin
			subkeys_q.k1 <= sdes_pkg::perm_p8(rot1);
			subkeys_q.k2 <= sdes_pkg::perm_p8(rot2);
		end
	end

	assign subkeys = subkeys_q;

endmodule

/* hdl/sdes_fk.sv */
// one feistel round fk: expansion, subkey xor, two s-boxes, p4, xor into left nibble
// depends on sdes_pkg
module sdes_fk (
	input  sdes_pkg::byte_t din,
	input  sdes_pkg::byte_t subkey,
	output sdes_pkg::byte_t dout
);

	sdes_pkg::byte_t t;
	sdes_pkg::nib_t  s;

	assign t    = sdes_pkg::perm_ep(din[3:0]) ^ subkey;
	assign s    = {sdes_pkg::SBOX0[sdes_pkg::sbox_idx(t[7:4])],
	               sdes_pkg::SBOX1[sdes_pkg::sbox_idx(t[3:0])]};
	assign dout = {din[7:4] ^ sdes_pkg::perm_p4(s), din[3:0]};

endmodule

/* hdl/sdes_byte_cipher_top.sv */
// top level of the s-des byte cipher: key schedule and a three-stage round pipeline
// depends on sdes_pkg, sdes_keysched and sdes_fk
//
// channel   direction  handshake              payload
// plain     in         plain_valid/stall      plain_byte
// cipher    out        cipher_valid/stall     cipher_byte
// key       in         key_we                 key_wdata
//
// the stages are ip and round one, swap and round two, inverse ip into
// the output register. one byte enters every cycle while the output is taken.
// reset clears the stage valid bits and the subkeys (key zero).
// a stall on the output freezes each occupied stage with no empty stage after it;
// empty stages keep filling, so plain_stall rises only when all three stages hold a byte.
module sdes_byte_cipher_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_we,
	input  sdes_pkg::key_t        key_wdata,
	input  logic                  plain_valid,
	output logic                  plain_stall,
	input  sdes_pkg::byte_t       plain_byte,
	output logic                  cipher_valid,
	input  logic                  cipher_stall,
	output sdes_pkg::byte_t       cipher_byte
);

	sdes_pkg::subkeys_t subkeys;
	sdes_pkg::byte_t    fk1_out;
	sdes_pkg::byte_t    fk2_out;
	sdes_pkg::byte_t    data_s1;
	sdes_pkg::byte_t    data_s2;
	sdes_pkg::byte_t    data_s3;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               en1;
	logic               en2;
	logic               en3;

	sdes_keysched u_keysched (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_we    (key_we),
		.key_wdata (key_wdata),
		.subkeys   (subkeys)
	);

	sdes_fk u_fk1 (
		.din    (sdes_pkg::perm_ip(plain_byte)),
		.subkey (subkeys.k1),
		.dout   (fk1_out)
	);

	// nibble swap between the rounds
	sdes_fk u_fk2 (
		.din    ({data_s1[3:0], data_s1[7:4]}),
		.subkey (subkeys.k2),
		.dout   (fk2_out)
	);

	// a stage moves when it is empty or the next one moves
	assign en3         = !valid_s3 || !cipher_stall;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign plain_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= plain_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) data_s1 <= fk1_out;
		if (en2) data_s2 <= fk2_out;
		if (en3) data_s3 <= sdes_pkg::perm_ipinv(data_s2);
	end

	assign cipher_valid = valid_s3;
	assign cipher_byte  = data_s3;

	// back-pressure reaches the input only with a full pipeline and a stalled output
	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		plain_stall |-> (valid_s1 && valid_s2 && valid_s3 && cipher_stall))
		else $error("input stalled without a full, stalled pipeline");

	// an accepted transaction lands in the first stage
	a_accept_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(plain_valid && !plain_stall) |=> valid_s1)
		else $error("accepted transaction missing from stage one");

	// a held middle stage keeps its byte
	a_hold_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en2) |=> (valid_s2 && $stable(data_s2)))
		else $error("stage two lost or changed a held byte");

	// a byte in stage two cannot vanish while the output moves
	a_drain_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en3) |=> valid_s3)
		else $error("stage two byte dropped on the way out");

endmodule

/* sim/sdes_cipher_check_pkg.sv */
// expected-byte tracking for the s-des byte cipher bench: a bit-level encryptor
// and a small checker class; depends on sdes_pkg for the key and byte types
package sdes_cipher_check_pkg;

	import sdes_pkg::*;

	// entry k (from the msb) is the 1-based source bit, counted from the msb
	// shorter tables are zero-padded at the top to the common 40-bit width
	localparam logic [39:0] P10_TAB   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
		4'd8, 4'd6};
	localparam logic [39:0] P8_TAB    = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10,
		4'd9};
	localparam logic [39:0] IP_TAB    = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5,
		4'd7};
	localparam logic [39:0] IPINV_TAB = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8,
		4'd6};
	localparam logic [39:0] EP_TAB    = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4,
		4'd1};
	localparam logic [39:0] P4_TAB    = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};

	// s-boxes, row-major, first entry in the top bits
	localparam logic [31:0] S0_TAB = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
	localparam logic [31:0] S1_TAB = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

	function automatic logic [9:0] pick_bits(input logic [9:0] v, input int in_w,
			input logic [39:0] tab, input int out_w);
		logic [9:0] r;
		int src;
		int k;
		r = '0;
		for (k = 0; k < out_w; k++) begin
			src = int'(tab[4*(out_w-1-k) +: 4]);
			r = {r[8:0], v[in_w-src]};
		end
		return r;
	endfunction

	function automatic key_t rotate_halves(input key_t v, input int n);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = v[9:5];
		lo = v[4:0];
		hi = (hi << n) | (hi >> (5 - n));
		lo = (lo << n) | (lo >> (5 - n));
		return {hi, lo};
	endfunction

	function automatic logic [1:0] sbox_out(input logic [31:0] box, input nib_t n);
		int idx;
		idx = int'({n[3], n[0], n[2:1]});
		return box[2*(15-idx) +: 2];
	endfunction

	function automatic byte_t feistel_round(input byte_t b, input byte_t subkey);
		logic [9:0] t;
		logic [9:0] f;
		t = pick_bits({6'd0, b[3:0]}, 4, EP_TAB, 8);
		t[7:0] = t[7:0] ^ subkey;
		f = pick_bits({6'd0, sbox_out(S0_TAB, t[7:4]), sbox_out(S1_TAB, t[3:0])}, 4, P4_TAB, 4);
		return {b[7:4] ^ f[3:0], b[3:0]};
	endfunction

	function automatic byte_t encrypt_byte(input key_t key, input byte_t plain);
		key_t k10;
		key_t r1;
		key_t r2;
		logic [9:0] k1;
		logic [9:0] k2;
		logic [9:0] b;
		k10 = pick_bits(key, 10, P10_TAB, 10);
		r1 = rotate_halves(k10, 1);
		r2 = rotate_halves(r1, 2);
		k1 = pick_bits(r1, 10, P8_TAB, 8);
		k2 = pick_bits(r2, 10, P8_TAB, 8);
		b = pick_bits({2'd0, plain}, 8, IP_TAB, 8);
		b[7:0] = feistel_round(b[7:0], k1[7:0]);
		b[7:0] = {b[3:0], b[7:4]};
		b[7:0] = feistel_round(b[7:0], k2[7:0]);
		b = pick_bits(b, 8, IPINV_TAB, 8);
		return b[7:0];
	endfunction

	class cipher_checker;
		byte_t expected_cipher_q[$];
		key_t key;
		int unsigned mismatches;
		int unsigned matched;

		function new();
			key = '0;
			mismatches = 0;
			matched = 0;
		endfunction

		function void load_key(input key_t k);
			key = k;
		endfunction

		function void note_plain(input byte_t plain);
			expected_cipher_q.push_back(encrypt_byte(key, plain));
		endfunction

		function void check_cipher(input byte_t got);
			byte_t want;
			if (expected_cipher_q.size() == 0) begin
				$display("%0t: cipher_byte expected none, actual %02h", $time, got);
				mismatches++;
				return;
			end
			want = expected_cipher_q.pop_front();
			if (got !== want) begin
				$display("%0t: cipher_byte expected %02h, actual %02h", $time, want, got);
				mismatches++;
			end else begin
				matched++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_cipher_q.size();
		endfunction
	endclass

endpackage

/* sim/tb_sdes_byte_cipher_top.sv */
// bench for sdes_byte_cipher_top: random and directed bytes under several keys,
// with random source gaps and sink stalls; depends on sdes_pkg and sdes_cipher_check_pkg
module tb_sdes_byte_cipher_top;

	import sdes_pkg::*;
	import sdes_cipher_check_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  key_we;
	key_t  key_wdata;
	logic  plain_valid;
	logic  plain_stall;
	byte_t plain_byte;
	logic  cipher_valid;
	logic  cipher_stall;
	byte_t cipher_byte;

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned keys_written = 0;
	cipher_checker chk;

	sdes_byte_cipher_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_we       (key_we),
		.key_wdata    (key_wdata),
		.plain_valid  (plain_valid),
		.plain_stall  (plain_stall),
		.plain_byte   (plain_byte),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher_byte  (cipher_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("timeout with %0d bytes still outstanding", chk.outstanding());
		$display("Simulation FAILED");
		$finish;
	end

	// sink side: long hold-offs take priority over random stalls
	initial begin
		cipher_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				cipher_stall = 1'b1;
				hold_left--;
			end else begin
				cipher_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cipher_valid && !cipher_stall)
			chk.check_cipher(cipher_byte);
	end

	// called at a falling edge; returns at a falling edge with valid possibly still high
	task automatic send_plain(input byte_t p);
		plain_byte = p;
		plain_valid = 1'b1;
		do @(posedge clk); while (plain_stall);
		chk.note_plain(p);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			plain_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain_cipher();
		plain_valid = 1'b0;
		do @(negedge clk); while (chk.outstanding() != 0);
	endtask

	task automatic change_key(input key_t k);
		drain_cipher();
		repeat (4) @(negedge clk);
		key_we = 1'b1;
		key_wdata = k;
		@(negedge clk);
		key_we = 1'b0;
		chk.load_key(k);
		keys_written++;
	endtask

	initial begin
		byte_t directed [$];
		int unsigned phase;
		int unsigned n;
		chk = new();
		arst_n = 1'b0;
		key_we = 1'b0;
		key_wdata = '0;
		plain_valid = 1'b0;
		plain_byte = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes of data and key, plus the textbook key and plaintext
		directed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
		change_key(10'h000);
		foreach (directed[i]) send_plain(directed[i]);
		change_key(10'h3FF);
		foreach (directed[i]) send_plain(directed[i]);
		change_key(10'h282);
		send_plain(8'h97);
		send_plain(8'h00);
		change_key(10'h155);
		send_plain(8'h5A);
		send_plain(8'hA5);
		change_key(10'h2AA);
		send_plain(8'h0F);
		send_plain(8'hF0);

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 50; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 50; end
				default: begin gap_pct = 7; stall_pct = 7; end
			endcase
			if (phase == 0)
				change_key(10'h000);
			else if (phase == 1)
				change_key(10'h3FF);
			else
				change_key(key_t'($urandom_range(1023)));
			for (n = 0; n < 210; n++) begin
				if (phase == 2 && n == 100)
					hold_left = 60;   // pipeline fills up, input must back off
				if (phase == 5 && n == 100)
					drain_cipher();
				send_plain(byte_t'($urandom_range(255)));
			end
		end

		drain_cipher();
		repeat (6) @(negedge clk);
		$display("%0d cipher bytes checked under %0d key settings", chk.matched, keys_written);
		$display("idle mixes: none, source gaps, sink stalls, both light; one long sink hold-off");
		if (chk.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
hdl/sdes_pkg.sv
hdl/sdes_keysched.sv
hdl/sdes_fk.sv
hdl/sdes_byte_cipher_top.sv
sim/sdes_cipher_check_pkg.sv
sim/tb_sdes_byte_cipher_top.sv
